// ----- src/spatial_grid_bucket_index_macros.svh -----
// Assertion macros for the spatial grid bucket index checker.
`ifndef SPATIAL_GRID_BUCKET_INDEX_MACROS_SVH
`define SPATIAL_GRID_BUCKET_INDEX_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define SGBI_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define SGBI_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/sgbi_pkg.sv -----
// Shared types and constants for the spatial grid bucket index.
package sgbi_pkg;

    localparam int COORD_W   = 16;
    localparam int P2_W      = COORD_W + 2;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int ID_W      = 5;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int GRID_W    = 5;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [COORD_W-1:0]        size_t_t;
    typedef logic [KIND_W-1:0]         kind_t;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam kind_t KIND_INSERT_DONE = 2'd0;
    localparam kind_t KIND_QUERY_HIT   = 2'd1;
    localparam kind_t KIND_QUERY_EMPTY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 3'd5;

endpackage

// ----- src/sgbi_mem.sv -----
// Cell bitmap memory: one write port, one registered read port.
module sgbi_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 32
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/sgbi_div.sv -----
// Shared scale-and-divide unit: the product is registered on start, then one quotient bit per cycle.
module sgbi_div #(
    parameter int QW = 4
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [sgbi_pkg::DIFF_W-1:0] diff,
    input  logic [QW-1:0]               scale,
    input  logic [sgbi_pkg::DIFF_W-1:0] den,
    output logic                        done,
    output logic [QW-1:0]               quo
);

    localparam int NW  = sgbi_pkg::DIFF_W + QW;
    localparam int QCW = (QW > 1) ? $clog2(QW) : 1;

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [QCW-1:0]              cnt_reg, cnt_next;
    logic [NW-1:0]               rem_reg, rem_next;
    logic [sgbi_pkg::DIFF_W-1:0] den_reg, den_next;
    logic [QW-1:0]               quo_reg, quo_next;
    logic [NW-1:0]               shifted;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        shifted   = NW'(den_reg) << cnt_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = QCW'(QW - 1);
            rem_next  = NW'(diff) * NW'(scale);
            den_next  = den;
            quo_next  = '0;
        end else if (busy_reg) begin
            if (rem_reg >= shifted) begin
                rem_next          = rem_reg - shifted;
                quo_next[cnt_reg] = 1'b1;
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ----- src/spatial_grid_bucket_index.sv -----
// Spatial grid bucket index: top level with sequencer, config registers and result stage.
//
//  channel  handshake          payload
//  s_       s_valid/s_ready    op, entity_id, center_x, center_y, box_width, box_height
//  m_       m_valid/m_ready    kind, found_id, last
//  cfg_     cfg_we             cfg_index, cfg_data
//
// An item takes 4 corner mappings on the shared divider (an empty axis range skips it),
// then a memory read and then an update per covered cell, then one result beat per
// cycle while m_ready stays high.
// After reset a clearing pass over all GRID_COLS_MAX*GRID_ROWS_MAX cells runs with s_ready low.
// A stalled m_ready holds the sequencer in its result step; s_ready is high only when idle.
module spatial_grid_bucket_index #(
    parameter int MAX_ENTITIES  = 32,
    parameter int GRID_COLS_MAX = 16,
    parameter int GRID_ROWS_MAX = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_op,
    input  logic [sgbi_pkg::ID_W-1:0]      s_entity_id,
    input  sgbi_pkg::coord_t               s_center_x,
    input  sgbi_pkg::coord_t               s_center_y,
    input  logic [sgbi_pkg::COORD_W-1:0]   s_box_width,
    input  logic [sgbi_pkg::COORD_W-1:0]   s_box_height,
    output logic                           m_valid,
    input  logic                           m_ready,
    output sgbi_pkg::kind_t                m_kind,
    output logic [sgbi_pkg::ID_W-1:0]      m_found_id,
    output logic                           m_last,
    input  logic                           cfg_we,
    input  logic [sgbi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sgbi_pkg::COORD_W-1:0]   cfg_data
);

    localparam int CELL_COUNT = GRID_COLS_MAX * GRID_ROWS_MAX;
    localparam int AW      = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int CW      = (GRID_COLS_MAX > 1) ? $clog2(GRID_COLS_MAX) : 1;
    localparam int RW      = (GRID_ROWS_MAX > 1) ? $clog2(GRID_ROWS_MAX) : 1;
    localparam int DIM_MAX = (GRID_COLS_MAX > GRID_ROWS_MAX) ? GRID_COLS_MAX : GRID_ROWS_MAX;
    localparam int QW      = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
    localparam int IDW     = (MAX_ENTITIES > 1) ? $clog2(MAX_ENTITIES) : 1;
    localparam int DW      = sgbi_pkg::DIFF_W;
    localparam int PW      = sgbi_pkg::P2_W;
    localparam int GW      = sgbi_pkg::GRID_W;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_PREP   = 3'd2;
    localparam logic [2:0] ST_DSTART = 3'd3;
    localparam logic [2:0] ST_DWAIT  = 3'd4;
    localparam logic [2:0] ST_RD     = 3'd5;
    localparam logic [2:0] ST_UPD    = 3'd6;
    localparam logic [2:0] ST_EMIT   = 3'd7;

    logic [2:0] state_reg, state_next;

    sgbi_pkg::coord_t min_x_reg, min_y_reg, max_x_reg, max_y_reg;
    logic [GW-1:0]    cols_reg, rows_reg;

    logic                           op_reg, op_next;
    logic [sgbi_pkg::ID_W-1:0]      id_reg, id_next;
    sgbi_pkg::coord_t               cx_reg, cx_next, cy_reg, cy_next;
    logic [sgbi_pkg::COORD_W-1:0]   w_reg, w_next, h_reg, h_next;

    logic [1:0]          corner_reg, corner_next;
    logic [QW-1:0]       q_reg [4];
    logic [QW-1:0]       q_next [4];
    logic [DW-1:0]       diff_reg, diff_next, den_reg, den_next;
    logic [QW-1:0]       scale_reg, scale_next;

    logic [RW-1:0]       r_reg, r_next;
    logic [CW-1:0]       c_reg, c_next;
    logic [AW-1:0]       clr_reg, clr_next;
    logic [MAX_ENTITIES-1:0] acc_reg, acc_next;

    logic                      mv_reg, mv_next, ml_reg, ml_next;
    sgbi_pkg::kind_t           mk_reg, mk_next;
    logic [sgbi_pkg::ID_W-1:0] mid_reg, mid_next;

    // corner mapping
    logic                    axis_y, neg;
    sgbi_pkg::coord_t        cc, lo, hi;
    logic [sgbi_pkg::COORD_W-1:0] sz;
    logic signed [PW-1:0]    c2, s2, p2, lo2, hi2, pc, dp, dh;
    logic [8:0]              dim_ext;
    logic [QW-1:0]           dim_m1;

    // walk and result
    logic [AW-1:0]           addr;
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic [MAX_ENTITIES-1:0] mem_wdata, mem_rdata, ins_bit, low_bit;
    logic [IDW-1:0]          low_idx;
    logic [IDW+sgbi_pkg::ID_W-1:0] low_ext;
    logic                    div_start, div_done;
    logic [QW-1:0]           div_quo;
    logic                    can_load;

    sgbi_div #(.QW(QW)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .diff    (diff_reg),
        .scale   (scale_reg),
        .den     (den_reg),
        .done    (div_done),
        .quo     (div_quo)
    );

    sgbi_mem #(.DEPTH(CELL_COUNT), .AW(AW), .DW(MAX_ENTITIES)) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (addr),
        .rdata (mem_rdata)
    );

    always_comb begin
        axis_y = corner_reg[1];
        neg    = !corner_reg[0];
        cc     = axis_y ? cy_reg : cx_reg;
        sz     = axis_y ? h_reg : w_reg;
        lo     = axis_y ? min_y_reg : min_x_reg;
        hi     = axis_y ? max_y_reg : max_x_reg;
        c2     = {cc[sgbi_pkg::COORD_W-1], cc, 1'b0};
        s2     = {2'b00, sz};
        p2     = neg ? (c2 - s2) : (c2 + s2);
        lo2    = {lo[sgbi_pkg::COORD_W-1], lo, 1'b0};
        hi2    = {hi[sgbi_pkg::COORD_W-1], hi, 1'b0};
        pc     = p2;
        if (p2 < lo2) begin
            pc = lo2;
        end
        if (p2 > hi2) begin
            pc = hi2;
        end
        dp      = pc - lo2;
        dh      = hi2 - lo2;
        dim_ext = {4'b0000, (axis_y ? rows_reg : cols_reg)};
        if (dim_ext == 9'd0) begin
            dim_m1 = '0;
        end else if (dim_ext > 9'(axis_y ? GRID_ROWS_MAX : GRID_COLS_MAX)) begin
            dim_m1 = QW'((axis_y ? GRID_ROWS_MAX : GRID_COLS_MAX) - 1);
        end else begin
            dim_m1 = QW'(dim_ext - 9'd1);
        end
    end

    always_comb begin
        addr    = AW'(int'(r_reg) * GRID_COLS_MAX + int'(c_reg));
        ins_bit = '0;
        for (int k = 0; k < MAX_ENTITIES; k++) begin
            ins_bit[k] = (op_reg == sgbi_pkg::OP_INSERT) && (int'(id_reg) == k);
        end
        low_idx = '0;
        for (int k = MAX_ENTITIES - 1; k >= 0; k--) begin
            if (acc_reg[k]) begin
                low_idx = IDW'(k);
            end
        end
        low_bit = '0;
        low_bit[low_idx] = 1'b1;
        low_ext = {{sgbi_pkg::ID_W{1'b0}}, low_idx};
    end

    assign can_load = !mv_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        id_next     = id_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        w_next      = w_reg;
        h_next      = h_reg;
        corner_next = corner_reg;
        q_next      = q_reg;
        diff_next   = diff_reg;
        den_next    = den_reg;
        scale_next  = scale_reg;
        r_next      = r_reg;
        c_next      = c_reg;
        clr_next    = clr_reg;
        acc_next    = acc_reg;
        mv_next     = mv_reg && !m_ready;
        ml_next     = ml_reg;
        mk_next     = mk_reg;
        mid_next    = mid_reg;
        div_start   = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = addr;
        mem_wdata   = mem_rdata | ins_bit;

        case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (int'(clr_reg) == CELL_COUNT - 1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    op_next     = s_op;
                    id_next     = s_entity_id;
                    cx_next     = s_center_x;
                    cy_next     = s_center_y;
                    w_next      = s_box_width;
                    h_next      = s_box_height;
                    corner_next = 2'd0;
                    state_next  = ST_PREP;
                end
            end
            ST_PREP: begin
                diff_next  = DW'(dp);
                den_next   = DW'(dh);
                scale_next = dim_m1;
                if (hi <= lo) begin
                    q_next[corner_reg] = '0;
                    corner_next = corner_reg + 1'b1;
                    if (corner_reg == 2'd3) begin
                        r_next     = q_reg[2][RW-1:0];
                        c_next     = q_reg[0][CW-1:0];
                        acc_next   = '0;
                        state_next = ST_RD;
                    end
                end else begin
                    state_next = ST_DSTART;
                end
            end
            ST_DSTART: begin
                div_start  = 1'b1;
                state_next = ST_DWAIT;
            end
            ST_DWAIT: begin
                if (div_done) begin
                    q_next[corner_reg] = div_quo;
                    corner_next = corner_reg + 1'b1;
                    if (corner_reg == 2'd3) begin
                        r_next     = q_reg[2][RW-1:0];
                        c_next     = q_reg[0][CW-1:0];
                        acc_next   = '0;
                        state_next = ST_RD;
                    end else begin
                        state_next = ST_PREP;
                    end
                end
            end
            ST_RD: begin
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (op_reg == sgbi_pkg::OP_INSERT) begin
                    mem_we = 1'b1;
                end else begin
                    acc_next = acc_reg | mem_rdata;
                end
                state_next = ST_RD;
                if (c_reg == q_reg[1][CW-1:0]) begin
                    c_next = q_reg[0][CW-1:0];
                    if (r_reg == q_reg[3][RW-1:0]) begin
                        state_next = ST_EMIT;
                    end else begin
                        r_next = r_reg + 1'b1;
                    end
                end else begin
                    c_next = c_reg + 1'b1;
                end
            end
            ST_EMIT: begin
                if (can_load) begin
                    mv_next = 1'b1;
                    if (op_reg == sgbi_pkg::OP_INSERT) begin
                        mk_next    = sgbi_pkg::KIND_INSERT_DONE;
                        mid_next   = '0;
                        ml_next    = 1'b1;
                        state_next = ST_IDLE;
                    end else if (acc_reg == '0) begin
                        mk_next    = sgbi_pkg::KIND_QUERY_EMPTY;
                        mid_next   = '0;
                        ml_next    = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        mk_next  = sgbi_pkg::KIND_QUERY_HIT;
                        mid_next = low_ext[sgbi_pkg::ID_W-1:0];
                        acc_next = acc_reg & ~low_bit;
                        ml_next  = ((acc_reg & ~low_bit) == '0);
                        if ((acc_reg & ~low_bit) == '0) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            mv_reg    <= 1'b0;
            min_x_reg <= '0;
            min_y_reg <= '0;
            max_x_reg <= 16'sd1023;
            max_y_reg <= 16'sd1023;
            cols_reg  <= 5'd16;
            rows_reg  <= 5'd16;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            mv_reg    <= mv_next;
            if (cfg_we) begin
                case (cfg_index)
                    sgbi_pkg::CFG_MIN_X:     min_x_reg <= cfg_data;
                    sgbi_pkg::CFG_MIN_Y:     min_y_reg <= cfg_data;
                    sgbi_pkg::CFG_MAX_X:     max_x_reg <= cfg_data;
                    sgbi_pkg::CFG_MAX_Y:     max_y_reg <= cfg_data;
                    sgbi_pkg::CFG_GRID_COLS: cols_reg  <= cfg_data[GW-1:0];
                    sgbi_pkg::CFG_GRID_ROWS: rows_reg  <= cfg_data[GW-1:0];
                    default: ;
                endcase
            end
        end
        op_reg     <= op_next;
        id_reg     <= id_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        w_reg      <= w_next;
        h_reg      <= h_next;
        corner_reg <= corner_next;
        q_reg      <= q_next;
        diff_reg   <= diff_next;
        den_reg    <= den_next;
        scale_reg  <= scale_next;
        r_reg      <= r_next;
        c_reg      <= c_next;
        acc_reg    <= acc_next;
        ml_reg     <= ml_next;
        mk_reg     <= mk_next;
        mid_reg    <= mid_next;
    end

    assign m_valid    = mv_reg;
    assign m_kind     = mk_reg;
    assign m_found_id = mid_reg;
    assign m_last     = ml_reg;

endmodule

// ----- src/sgbi_checker.sv -----
// Port-level checker for the spatial grid bucket index, with its bind.
`include "spatial_grid_bucket_index_macros.svh"

module sgbi_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input sgbi_pkg::kind_t           m_kind,
    input logic [sgbi_pkg::ID_W-1:0] m_found_id,
    input logic                      m_last
);

    `SGBI_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid, "result beat dropped before accept")
    `SGBI_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready, "ready stayed high after accept")
    `SGBI_ASSERT_NOW(a_no_accept_mid_item, aclk, aresetn, m_valid && !m_last, !s_ready, "ready high while item results pending")
    `SGBI_ASSERT_NOW(a_id_zero, aclk, aresetn, m_valid && (m_kind != sgbi_pkg::KIND_QUERY_HIT), (m_found_id == '0) && m_last, "non-hit beat with id or not last")
    `SGBI_ASSERT_NOW(a_kind_legal, aclk, aresetn, m_valid, (m_kind == sgbi_pkg::KIND_INSERT_DONE) || (m_kind == sgbi_pkg::KIND_QUERY_HIT) || (m_kind == sgbi_pkg::KIND_QUERY_EMPTY), "illegal result kind")

endmodule

bind spatial_grid_bucket_index sgbi_checker u_sgbi_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_kind     (m_kind),
    .m_found_id (m_found_id),
    .m_last     (m_last)
);
